// ===== rtl/stmv_pkg.sv =====
// ---------------------------------------------------------------------------
// stmv_pkg
// Shared types and constants of the sparse transpose mat-vec tree core:
// word formats, action codes, controller states and datapath commands.
// ---------------------------------------------------------------------------
package stmv_pkg;

    // fixed field widths
    localparam int NUM_COLS_W = 11;
    localparam int OUT_W      = 48;
    localparam int PROD_W     = 40;

    // action codes carried in the input word
    localparam logic [2:0] ACT_LOAD_B     = 3'd0;
    localparam logic [2:0] ACT_SET_PARENT = 3'd1;
    localparam logic [2:0] ACT_ADD_TERM   = 3'd2;
    localparam logic [2:0] ACT_PROPAGATE  = 3'd3;
    localparam logic [2:0] ACT_READ_W     = 3'd4;
    localparam logic [2:0] ACT_CLEAR_W    = 3'd5;

    // input word
    typedef struct packed {
        logic        [2:0]  action;
        logic        [9:0]  column;
        logic        [11:0] row_index;
        logic signed [7:0]  coefficient;
        logic signed [31:0] b_value;
        logic        [9:0]  parent_index;
    } in_word_t;

    // result word
    typedef struct packed {
        logic signed [OUT_W-1:0] w_value;
        logic                    read_valid;
    } out_word_t;

    // controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_TERM_MUL,
        S_TERM_WR,
        S_PROP_PAR,
        S_PROP_RD,
        S_PROP_ADD,
        S_CLEAR,
        S_RESP
    } ctl_state_t;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_B,
        OP_SET_PARENT,
        OP_TERM_READ,
        OP_TERM_MUL,
        OP_TERM_WRITE,
        OP_PROP_START,
        OP_PROP_PARENT,
        OP_PROP_READ,
        OP_PROP_WRITE,
        OP_READ_W,
        OP_CLEAR_START,
        OP_CLEAR_STEP,
        OP_RESULT
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic       prop_last;
        logic       clear_last;
        logic       multi_col;
        logic       out_free;
    } ctl_sts_t;

endpackage

// ===== rtl/stmv_ctrl.sv =====
// ---------------------------------------------------------------------------
// stmv_ctrl
// Sequencer of the core: takes one word at a time, steps the datapath
// through the work of its action and hands the result to the output stage.
// ---------------------------------------------------------------------------
module stmv_ctrl
    import stmv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register, starts with the accumulator sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.action)
                    ACT_ADD_TERM:  state_next = S_TERM_MUL;
                    ACT_PROPAGATE: state_next = sts.multi_col ? S_PROP_PAR : S_RESP;
                    ACT_CLEAR_W:   state_next = S_CLEAR;
                    default:       state_next = S_RESP;
                endcase
            end
            S_TERM_MUL: state_next = S_TERM_WR;
            S_TERM_WR:  state_next = S_RESP;
            S_PROP_PAR: state_next = S_PROP_RD;
            S_PROP_RD:  state_next = S_PROP_ADD;
            S_PROP_ADD: state_next = sts.prop_last ? S_RESP : S_PROP_PAR;
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_INIT: cmd.op = OP_CLEAR_STEP;
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_CAPTURE : OP_NONE;
            end
            S_DISPATCH:
            begin
                unique case (sts.action)
                    ACT_LOAD_B:     cmd.op = OP_LOAD_B;
                    ACT_SET_PARENT: cmd.op = OP_SET_PARENT;
                    ACT_ADD_TERM:   cmd.op = OP_TERM_READ;
                    ACT_PROPAGATE:  cmd.op = OP_PROP_START;
                    ACT_READ_W:     cmd.op = OP_READ_W;
                    ACT_CLEAR_W:    cmd.op = OP_CLEAR_START;
                    default:        cmd.op = OP_NONE;
                endcase
            end
            S_TERM_MUL: cmd.op = OP_TERM_MUL;
            S_TERM_WR:  cmd.op = OP_TERM_WRITE;
            S_PROP_PAR: cmd.op = OP_PROP_PARENT;
            S_PROP_RD:  cmd.op = OP_PROP_READ;
            S_PROP_ADD: cmd.op = OP_PROP_WRITE;
            S_CLEAR:    cmd.op = OP_CLEAR_STEP;
            S_RESP:     cmd.op = sts.out_free ? OP_RESULT : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/stmv_datapath.sv =====
// ---------------------------------------------------------------------------
// stmv_datapath
// Storage and arithmetic of the core: b, parent and accumulator memories,
// the coefficient multiplier, the saturating adder and the output register.
// ---------------------------------------------------------------------------
module stmv_datapath
    import stmv_pkg::*;
#(
    parameter int MAX_COLS  = 1024,
    parameter int MAX_ROWS  = 4096,
    parameter int ACC_WIDTH = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [NUM_COLS_W-1:0] cfg_data,
    input  in_word_t              in_word,
    input  ctl_cmd_t              cmd,
    output ctl_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    // memories
    logic signed [31:0]          b_mem [MAX_ROWS];
    logic        [9:0]           parent_mem [MAX_COLS];
    logic signed [ACC_WIDTH-1:0] w_mem [MAX_COLS];

    // registers
    logic        [CW:0]          n_reg;
    logic        [CW:0]          n_next;
    logic        [CW-1:0]        cnt_reg;
    logic        [CW-1:0]        cnt_next;
    in_word_t                    item_reg;
    logic signed [31:0]          b_rd_reg;
    logic        [9:0]           par_rd_reg;
    logic signed [ACC_WIDTH-1:0] w_rd_a_reg;
    logic signed [ACC_WIDTH-1:0] w_rd_b_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    out_word_t                   out_word_reg;
    out_word_t                   out_word_next;

    // decoded item and address signals
    logic [CW-1:0]               col_addr;
    logic [RW-1:0]               row_addr;
    logic [CW-1:0]               par_addr;
    logic                        col_in_use;
    logic                        col_in_range;
    logic                        row_in_range;
    logic                        par_in_use;

    // accumulator memory ports
    logic                        w_we;
    logic [CW-1:0]               w_waddr;
    logic signed [ACC_WIDTH-1:0] w_wdata;
    logic                        w_re_a;
    logic [CW-1:0]               w_raddr_a;
    logic                        w_re_b;

    // saturating adder
    logic signed [ACC_WIDTH-1:0] add_a;
    logic signed [ACC_WIDTH-1:0] add_b;
    logic signed [ACC_WIDTH:0]   add_sum;
    logic signed [ACC_WIDTH-1:0] add_sat;
    logic signed [OUT_W-1:0]     w_out_sat;

    // column count, clamped on write
    always_comb
    begin
        n_next = n_reg;
        if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                n_next = (CW+1)'(1);
            end
            else if (32'(cfg_data) > MAX_COLS)
            begin
                n_next = (CW+1)'(MAX_COLS);
            end
            else
            begin
                n_next = (CW+1)'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= (CW+1)'(MAX_COLS);
        end
        else
        begin
            n_reg <= n_next;
        end
    end

    // captured word
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            item_reg <= in_word;
        end
    end

    assign col_addr     = CW'(item_reg.column);
    assign row_addr     = RW'(item_reg.row_index);
    assign par_addr     = CW'(par_rd_reg);
    assign col_in_use   = 32'(item_reg.column) < 32'(n_reg);
    assign col_in_range = 32'(item_reg.column) < MAX_COLS;
    assign row_in_range = 32'(item_reg.row_index) < MAX_ROWS;
    assign par_in_use   = 32'(par_rd_reg) < 32'(n_reg);

    // column counter for propagate and clear sweeps
    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (cmd.op)
            OP_PROP_START:  cnt_next = CW'(1);
            OP_CLEAR_START: cnt_next = '0;
            OP_CLEAR_STEP,
            OP_PROP_WRITE:  cnt_next = cnt_reg + 1'b1;
            default:        cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // b memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD_B && row_in_range)
        begin
            b_mem[row_addr] <= item_reg.b_value;
        end
        if (cmd.op == OP_TERM_READ)
        begin
            b_rd_reg <= b_mem[row_addr];
        end
    end

    // parent memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SET_PARENT && col_in_range)
        begin
            parent_mem[col_addr] <= item_reg.parent_index;
        end
        if (cmd.op == OP_PROP_PARENT)
        begin
            par_rd_reg <= parent_mem[cnt_reg];
        end
    end

    // coefficient times b element
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_TERM_MUL)
        begin
            prod_reg <= item_reg.coefficient * b_rd_reg;
        end
    end

    // saturating add, shared by term and propagate
    always_comb
    begin
        add_a = w_rd_a_reg;
        if (cmd.op == OP_TERM_WRITE)
        begin
            add_b = ACC_WIDTH'(prod_reg);
        end
        else
        begin
            add_b = par_in_use ? w_rd_b_reg : '0;
        end
        add_sum = (ACC_WIDTH+1)'(add_a) + (ACC_WIDTH+1)'(add_b);
        if (add_sum[ACC_WIDTH] != add_sum[ACC_WIDTH-1])
        begin
            add_sat = add_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                         : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        else
        begin
            add_sat = add_sum[ACC_WIDTH-1:0];
        end
    end

    // accumulator memory port control
    always_comb
    begin
        w_we      = 1'b0;
        w_waddr   = cnt_reg;
        w_wdata   = add_sat;
        w_re_a    = 1'b0;
        w_raddr_a = col_addr;
        w_re_b    = 1'b0;
        unique case (cmd.op)
            OP_CLEAR_STEP:
            begin
                w_we    = 1'b1;
                w_wdata = '0;
            end
            OP_TERM_WRITE:
            begin
                w_we    = col_in_use && row_in_range;
                w_waddr = col_addr;
            end
            OP_PROP_WRITE:
            begin
                w_we = 1'b1;
            end
            OP_TERM_READ,
            OP_READ_W:
            begin
                w_re_a = 1'b1;
            end
            OP_PROP_READ:
            begin
                w_re_a    = 1'b1;
                w_raddr_a = cnt_reg;
                w_re_b    = 1'b1;
            end
            default:
            begin
                w_we = 1'b0;
            end
        endcase
    end

    // accumulator memory, one write and two read ports
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        if (w_re_a)
        begin
            w_rd_a_reg <= w_mem[w_raddr_a];
        end
        if (w_re_b)
        begin
            w_rd_b_reg <= w_mem[par_addr];
        end
    end

    // narrow the accumulator to the output width
    generate
        if (ACC_WIDTH > OUT_W)
        begin : g_out_sat
            logic [ACC_WIDTH-OUT_W:0] hi_bits;
            assign hi_bits = w_rd_a_reg[ACC_WIDTH-1:OUT_W-1];
            always_comb
            begin
                if ((&hi_bits) || (~|hi_bits))
                begin
                    w_out_sat = w_rd_a_reg[OUT_W-1:0];
                end
                else
                begin
                    w_out_sat = w_rd_a_reg[ACC_WIDTH-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                        : {1'b0, {(OUT_W-1){1'b1}}};
                end
            end
        end
        else
        begin : g_out_ext
            assign w_out_sat = OUT_W'(w_rd_a_reg);
        end
    endgenerate

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.op == OP_RESULT)
        begin
            out_valid_next           = 1'b1;
            out_word_next.read_valid = (item_reg.action == ACT_READ_W);
            out_word_next.w_value    = (item_reg.action == ACT_READ_W && col_in_use)
                                       ? w_out_sat : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // status to the controller
    assign sts.action     = item_reg.action;
    assign sts.prop_last  = (({1'b0, cnt_reg} + 1'b1) == n_reg);
    assign sts.clear_last = (cnt_reg == CW'(MAX_COLS - 1));
    assign sts.multi_col  = (n_reg != (CW+1)'(1));
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== rtl/sparse_transpose_matvec_tree_core.sv =====
// ---------------------------------------------------------------------------
// sparse_transpose_matvec_tree_core
// Computes w = A'*b from a column-difference form of A over a column tree,
// with Q15.16 b elements and saturating Q.16 accumulators.
// ---------------------------------------------------------------------------
// One word is worked at a time and every word returns exactly one result
// word. Load b, set parent, read w and unused actions go from dispatch
// straight to the result stage, add term reads b and the accumulator,
// multiplies and does a saturating write-back, propagate does for each
// column a parent read, a two-port accumulator read and an add-write,
// and clear w sweeps all MAX_COLS entries of the accumulator memory one
// entry per cycle. After reset the same sweep runs with in_ready low;
// num_cols may be written meanwhile. A finished result waits in the
// output register while the next word is taken.
module sparse_transpose_matvec_tree_core
    import stmv_pkg::*;
#(
    parameter int MAX_COLS  = 1024,
    parameter int MAX_ROWS  = 4096,
    parameter int ACC_WIDTH = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [NUM_COLS_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer
    stmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and arithmetic
    stmv_datapath #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

// ===== rtl/stmv_checker.sv =====
// ---------------------------------------------------------------------------
// stmv_port_checks
// Port-level checks of the core, attached to the top level by bind.
// ---------------------------------------------------------------------------
module stmv_port_checks
    import stmv_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // only one word in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in flight");

    // a new result never shows up while the core is open for input
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work in progress");

    // results of non-read words carry zero
    a_zero_non_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.read_valid |-> out_word.w_value == '0)
        else $error("non-read result carries a value");

endmodule

bind sparse_transpose_matvec_tree_core stmv_port_checks u_stmv_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

// ===== dv/stmv_checker.sv =====
// ---------------------------------------------------------------------------
// stmv_checker
// Watches the config port and both word channels of the sparse transpose
// mat-vec core, keeps its own copy of b, the parents and the accumulators,
// predicts the result of every accepted word and compares it in order.
// ---------------------------------------------------------------------------
module stmv_checker
    import stmv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [NUM_COLS_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_word_t              in_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_word_t             out_word,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_COLS = 1024;
    localparam int     MAX_ROWS = 4096;
    localparam longint ACC_HI   = 64'sd140737488355327;
    localparam longint ACC_LO   = -64'sd140737488355328;

    // mirrored block state
    int                    b_mem   [MAX_ROWS];
    bit [9:0]              par_mem [MAX_COLS];
    longint                w_acc   [MAX_COLS];
    logic [NUM_COLS_W-1:0] cols_reg = NUM_COLS_W'(MAX_COLS);

    // results still owed by the block, oldest first
    out_word_t w_result_q[$];

    // register value to number of columns in use
    function automatic int unsigned active_cols(logic [NUM_COLS_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_COLS)
            return MAX_COLS;
        return v;
    endfunction

    // saturating add into a 48-bit accumulator
    function automatic longint sat_acc(longint a, longint b);
        longint s;
        s = a + b;
        if (s > ACC_HI)
            return ACC_HI;
        if (s < ACC_LO)
            return ACC_LO;
        return s;
    endfunction

    // apply one word to the mirrored state and return the result word
    function automatic out_word_t matvec_step(in_word_t w);
        out_word_t   r;
        int unsigned n;
        int unsigned p;
        longint      prod;
        r = '0;
        n = active_cols(cols_reg);
        case (w.action)
            ACT_LOAD_B:
                b_mem[w.row_index] = $signed(w.b_value);
            ACT_SET_PARENT:
                par_mem[w.column] = w.parent_index;
            ACT_ADD_TERM:
                if (w.column < n)
                begin
                    prod = longint'($signed(w.coefficient)) * longint'(b_mem[w.row_index]);
                    w_acc[w.column] = sat_acc(w_acc[w.column], prod);
                end
            ACT_PROPAGATE:
                // children in increasing order, each sees its parent's current value
                for (int j = 1; j < n; j++)
                begin
                    p = par_mem[j];
                    if (p < n)
                        w_acc[j] = sat_acc(w_acc[j], w_acc[p]);
                end
            ACT_READ_W:
            begin
                r.read_valid = 1'b1;
                if (w.column < n)
                    r.w_value = w_acc[w.column][OUT_W-1:0];
            end
            ACT_CLEAR_W:
                foreach (w_acc[i])
                    w_acc[i] = 0;
            default: ;
        endcase
        return r;
    endfunction

    // sample handshakes, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            foreach (w_acc[i])
                w_acc[i] = 0;
            cols_reg = NUM_COLS_W'(MAX_COLS);
            w_result_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (w_result_q.size() == 0)
                begin
                    $display("%0t: unexpected result word w_value %0d read_valid %0b",
                             $time, $signed(out_word.w_value), out_word.read_valid);
                    fail_count++;
                end
                else
                begin
                    want = w_result_q.pop_front();
                    if (out_word.w_value !== want.w_value
                        || out_word.read_valid !== want.read_valid)
                    begin
                        $display("%0t: mismatch w_value exp %0d got %0d, read_valid exp %0b got %0b",
                                 $time, $signed(want.w_value), $signed(out_word.w_value),
                                 want.read_valid, out_word.read_valid);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                w_result_q.push_back(matvec_step(in_word));
            if (cfg_we)
                cols_reg = cfg_data;
            pending = w_result_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Drives the sparse transpose mat-vec core with a short directed sequence
// and then random phases at varying column counts, with random gaps on both
// channels, one long output hold-off and one full drain mid-phase.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import stmv_pkg::*;

    localparam int         TOTAL_ITEMS     = 1350;
    localparam int         WATCHDOG_LIMIT  = 20000;
    localparam int         HOLD_OFF_CYCLES = 200;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         TAIL_CYCLES     = 50;
    localparam int         MAX_COLS        = 1024;
    localparam logic [2:0] ACT_SPARE_LO    = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI    = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [NUM_COLS_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_ready;
    out_word_t             out_word;
    int                    fail_count;
    int                    pending;

    logic                  in_fire = 1'b0;
    int                    idle_cycles = 0;
    bit                    hold_off_req = 1'b0;

    // what the stimulus knows has been written
    bit                    b_written [4096];
    int                    b_rows_q[$];
    bit                    par_written [MAX_COLS];
    int                    cols_now = MAX_COLS;
    int                    gap_pct = 0;
    int                    items_sent = 0;

    sparse_transpose_matvec_tree_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    stmv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // input acceptance and stuck-run watchdog
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_idle(int pct);
        if ($urandom_range(1, 100) > pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic int eff_cols(int v);
        if (v == 0)
            return 1;
        if (v > MAX_COLS)
            return MAX_COLS;
        return v;
    endfunction

    function automatic in_word_t mk_word(logic [2:0] act, int col, int row, int coef,
                                         logic [31:0] bval, int par);
        in_word_t w;
        w.action       = act;
        w.column       = 10'(col);
        w.row_index    = 12'(row);
        w.coefficient  = 8'(coef);
        w.b_value      = bval;
        w.parent_index = 10'(par);
        return w;
    endfunction

    // random word, kept legal: terms use loaded rows, propagate needs all parents
    function automatic in_word_t make_word();
        in_word_t w;
        int       r;
        int       unset;
        w.column       = 10'($urandom_range(0, 1023));
        w.row_index    = 12'($urandom_range(0, 4095));
        w.coefficient  = 8'($urandom());
        w.b_value      = $urandom();
        w.parent_index = 10'($urandom_range(0, 1023));
        unset = 0;
        r = $urandom_range(0, 99);
        if (r < 10)
            w.action = ACT_LOAD_B;
        else if (r < 22)
            w.action = ACT_SET_PARENT;
        else if (r < 58)
            w.action = ACT_ADD_TERM;
        else if (r < 64)
            w.action = ACT_PROPAGATE;
        else if (r < 90)
            w.action = ACT_READ_W;
        else if (r < 92)
            w.action = ACT_CLEAR_W;
        else
            w.action = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;

        if (w.action == ACT_ADD_TERM && b_rows_q.size() == 0)
            w.action = ACT_LOAD_B;
        // fill the lowest missing parent instead of propagating
        if (w.action == ACT_PROPAGATE)
        begin
            for (int j = cols_now - 1; j >= 1; j--)
                if (!par_written[j])
                    unset = j;
            if (unset != 0)
            begin
                w.action = ACT_SET_PARENT;
                w.column = 10'(unset);
            end
        end

        case (w.action)
            ACT_LOAD_B:
            begin
                if ($urandom_range(0, 1))
                    w.row_index = 12'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                if (r < 15)
                    w.b_value = 32'sh7fffffff;
                else if (r < 30)
                    w.b_value = 32'sh80000000;
                else if (r < 35)
                    w.b_value = '0;
            end
            ACT_SET_PARENT:
            begin
                if (unset == 0 && $urandom_range(0, 99) < 85)
                    w.column = 10'($urandom_range(0, cols_now - 1));
                r = $urandom_range(0, 99);
                if (w.column != 0 && r < 45)
                    w.parent_index = w.column - 10'd1;
                else if (w.column != 0 && r < 70)
                    w.parent_index = 10'($urandom_range(0, w.column - 1));
                else if (r < 80)
                    w.parent_index = w.column;
            end
            ACT_ADD_TERM:
            begin
                w.row_index = 12'(b_rows_q[$urandom_range(0, b_rows_q.size() - 1)]);
                if ($urandom_range(0, 9) != 0)
                    w.column = 10'($urandom_range(0, cols_now - 1));
                r = $urandom_range(0, 99);
                if (r < 10)
                    w.coefficient = 8'sd127;
                else if (r < 20)
                    w.coefficient = -8'sd128;
            end
            ACT_READ_W:
                if ($urandom_range(0, 9) != 0)
                    w.column = 10'($urandom_range(0, cols_now - 1));
            default: ;
        endcase
        return w;
    endfunction

    // offer one word after an optional gap and wait until it is taken
    task automatic send_item(input in_word_t w);
        int gap;
        gap = pick_idle(gap_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (w.action == ACT_LOAD_B && !b_written[w.row_index])
        begin
            b_written[w.row_index] = 1'b1;
            b_rows_q.push_back(w.row_index);
        end
        if (w.action == ACT_SET_PARENT)
            par_written[w.column] = 1'b1;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(negedge clk);
        while (!in_fire);
        items_sent++;
    endtask

    // stop offering and wait for every owed result
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_cols(input int v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= NUM_COLS_W'(v);
        @(negedge clk);
        cfg_we   <= 1'b0;
        cols_now = eff_cols(v);
    endtask

    // result side: random stalls in bursts, plus the requested long hold-off
    initial
    begin
        int stall_left;
        int burst_left;
        int stall_pct;
        out_ready  = 1'b0;
        stall_left = 0;
        burst_left = 0;
        stall_pct  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(50, 300);
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        default: stall_pct = 50;
                    endcase
                end
                burst_left--;
                if (stall_left == 0)
                    stall_left = pick_idle(stall_pct);
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int phase;
        int len;
        int v;
        int r;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes of b, odd parents, edge columns, spare actions
        send_item(mk_word(ACT_LOAD_B, 0, 0, 0, 32'h7fffffff, 0));
        send_item(mk_word(ACT_LOAD_B, 0, 4095, 0, 32'h80000000, 0));
        send_item(mk_word(ACT_LOAD_B, 0, 5, 0, 32'h00010000, 0));
        send_item(mk_word(ACT_LOAD_B, 0, 6, 0, 32'hffffffff, 0));
        send_item(mk_word(ACT_SET_PARENT, 1, 0, 0, '0, 0));
        send_item(mk_word(ACT_SET_PARENT, 2, 0, 0, '0, 1));
        send_item(mk_word(ACT_SET_PARENT, 3, 0, 0, '0, 3));
        send_item(mk_word(ACT_SET_PARENT, 1023, 0, 0, '0, 1023));
        send_item(mk_word(ACT_ADD_TERM, 0, 0, 127, '0, 0));
        send_item(mk_word(ACT_ADD_TERM, 1023, 4095, -128, '0, 0));
        send_item(mk_word(ACT_ADD_TERM, 1, 5, -1, '0, 0));
        send_item(mk_word(ACT_ADD_TERM, 2, 6, 1, '0, 0));
        send_item(mk_word(ACT_READ_W, 0, 0, 0, '0, 0));
        send_item(mk_word(ACT_READ_W, 1023, 0, 0, '0, 0));
        send_item(mk_word(ACT_SPARE_LO, 0, 0, 0, '0, 0));
        send_item(mk_word(ACT_SPARE_HI, 1023, 4095, -1, 32'hffffffff, 1023));
        // four columns: parent self-loop, reads and a term beyond the range
        set_cols(4);
        send_item(mk_word(ACT_PROPAGATE, 0, 0, 0, '0, 0));
        send_item(mk_word(ACT_READ_W, 1, 0, 0, '0, 0));
        send_item(mk_word(ACT_READ_W, 2, 0, 0, '0, 0));
        send_item(mk_word(ACT_READ_W, 3, 0, 0, '0, 0));
        send_item(mk_word(ACT_READ_W, 4, 0, 0, '0, 0));
        send_item(mk_word(ACT_ADD_TERM, 5, 0, 1, '0, 0));
        send_item(mk_word(ACT_READ_W, 1023, 0, 0, '0, 0));
        send_item(mk_word(ACT_CLEAR_W, 0, 0, 0, '0, 0));
        send_item(mk_word(ACT_READ_W, 0, 0, 0, '0, 0));

        // random phases, each at its own column count
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            case (phase)
                0: v = 2047;
                1: v = 24;
                2: v = 0;
                3: v = 1;
                4: v = MAX_COLS;
                default:
                begin
                    r = $urandom_range(0, 99);
                    if (r < 6)
                        v = 0;
                    else if (r < 12)
                        v = 1;
                    else if (r < 18)
                        v = MAX_COLS;
                    else if (r < 24)
                        v = $urandom_range(MAX_COLS + 1, 2047);
                    else if (r < 32)
                        v = 2;
                    else
                        v = $urandom_range(3, 48);
                end
            endcase
            set_cols(v);
            len = (phase == 1) ? 100 : $urandom_range(40, 120);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            if (phase == 1)
                gap_pct = 0;
            for (int k = 0; k < len && items_sent < TOTAL_ITEMS; k++)
            begin
                // long result hold-off while words keep coming
                if (phase == 1 && k == 10)
                    hold_off_req = 1'b1;
                // full drain in the middle of a phase
                if (phase == 2 && k == 30)
                    wait_idle();
                send_item(make_word());
            end
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
